### hw/rtl/mbps_pkg.sv
package mbps_pkg;

   // pattern size and offset counter width
   localparam int MAX_PATTERN_BYTES = 16;
   localparam int OFFSET_BITS       = 32;
   localparam int ADDR_BITS         = 48;
   localparam int LEN_BITS          = 5;
   localparam int CSR_DATA_BITS     = 64;
   localparam int CSR_INDEX_BITS    = 3;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WILDCARD_MASK  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_ADDRESS   = 3'd4;

   // input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   // result word
   typedef struct packed {
      logic                 found;
      logic [ADDR_BITS-1:0] match_address;
   } rsp_word_type;

endpackage

### hw/rtl/masked_byte_pattern_scanner.sv
// Masked byte pattern scanner.
// The req channel carries one byte of a memory region per word, with
// last_byte marking the final byte. Each byte enters a 16-byte window that
// is compared in parallel with the configured pattern; wildcard bits mark
// pattern bytes that match anything.
// The rsp channel carries at most one word per region: found=1 and
// base_address plus the match offset at the first match (later bytes of
// the region are dropped), or found=0 with address 0 on the final byte
// when nothing matched. Scan state clears after the final byte.
// A byte is held in the input register, then compared into the result
// register, which holds the result word.
// Throughput: one byte per cycle while rsp_stall holds no result, set by the window compare.
// When rsp_stall holds a result, the input register holds its byte and
// req_stall rises once that register is full; no word is lost.
// Reset (synchronous) clears the scan state, both pipeline stages and the
// configuration registers (pattern_length resets to 1, others to 0).
// The csr port writes a register at every edge with csr_write_enable high;
// writes must be made only while the block is idle; the block does not enforce this.
module masked_byte_pattern_scanner
   import mbps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_word_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_data
);

   // configuration registers
   logic [63:0]           pattern_low_ff;
   logic [63:0]           pattern_high_ff;
   logic [15:0]           wildcard_mask_ff;
   logic [LEN_BITS-1:0]   pattern_length_ff;
   logic [ADDR_BITS-1:0]  base_address_ff;

   // pattern lined up with window entries, rebuilt every cycle from config
   logic [7:0]            aligned_byte_ff [MAX_PATTERN_BYTES];
   logic [7:0]            aligned_byte_in [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] aligned_care_ff;
   logic [MAX_PATTERN_BYTES-1:0] aligned_care_in;
   logic [LEN_BITS-1:0]   eff_length_ff;
   logic [LEN_BITS-1:0]   eff_length_in;

   // input stage
   logic                  s1_valid_ff;
   req_word_type          s1_word_ff;

   // scan state
   logic [7:0]            window_ff [MAX_PATTERN_BYTES];
   logic [7:0]            window_in [MAX_PATTERN_BYTES];
   logic [OFFSET_BITS-1:0] position_ff;
   logic [OFFSET_BITS-1:0] position_in;
   logic                  done_ff;
   logic                  done_in;
   logic [LEN_BITS-1:0]   fill_ff;
   logic [LEN_BITS-1:0]   fill_in;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_word_type          rsp_word_ff;
   rsp_word_type          rsp_word_in;

   logic                  advance;
   logic                  process;
   logic                  window_hit;
   logic                  match;
   logic [LEN_BITS-1:0]   fill_next;
   logic [MAX_PATTERN_BYTES-1:0] byte_ok;
   logic [OFFSET_BITS-1:0] match_offset;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         wildcard_mask_ff  <= '0;
         pattern_length_ff <= LEN_BITS'(1);
         base_address_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_write_data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_write_data;
            CSR_WILDCARD_MASK:  wildcard_mask_ff  <= csr_write_data[15:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_write_data[LEN_BITS-1:0];
            CSR_BASE_ADDRESS:   base_address_ff   <= csr_write_data[ADDR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective length and pattern byte for each window entry
   always_comb begin
      logic [127:0]  full_pattern;
      logic [LEN_BITS-1:0] src;
      full_pattern = {pattern_high_ff, pattern_low_ff};
      if (pattern_length_ff == '0) begin
         eff_length_in = LEN_BITS'(1);
      end else if (pattern_length_ff > LEN_BITS'(MAX_PATTERN_BYTES)) begin
         eff_length_in = LEN_BITS'(MAX_PATTERN_BYTES);
      end else begin
         eff_length_in = pattern_length_ff;
      end
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         // window entry i lines up with pattern byte len-1-i
         src = eff_length_in - LEN_BITS'(1) - LEN_BITS'(i);
         aligned_byte_in[i] = full_pattern[src[3:0]*8 +: 8];
         aligned_care_in[i] = (LEN_BITS'(i) < eff_length_in) && !wildcard_mask_ff[src[3:0]];
      end
   end

   always_ff @(posedge clock) begin
      aligned_byte_ff <= aligned_byte_in;
      aligned_care_ff <= aligned_care_in;
      eff_length_ff   <= eff_length_in;
   end

   // pipeline moves when the result register is free or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign process   = s1_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_word_ff <= req_data;
      end
   end

   // window shift and parallel compare
   always_comb begin
      window_in[0] = s1_word_ff.data_byte;
      for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
         window_in[i] = window_ff[i-1];
      end
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         byte_ok[i] = !aligned_care_ff[i] || (window_in[i] == aligned_byte_ff[i]);
      end
   end

   assign fill_next    = (fill_ff < LEN_BITS'(MAX_PATTERN_BYTES)) ? fill_ff + LEN_BITS'(1)
                                                                : fill_ff;
   assign window_hit   = &byte_ok;
   assign match        = !done_ff && (fill_next >= eff_length_ff) && window_hit;
   assign match_offset = position_ff - OFFSET_BITS'(eff_length_ff - LEN_BITS'(1));

   // result word
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !advance;
      rsp_word_in  = rsp_word_ff;
      if (process) begin
         if (match) begin
            rsp_valid_in              = 1'b1;
            rsp_word_in.found         = 1'b1;
            rsp_word_in.match_address = base_address_ff + ADDR_BITS'(match_offset);
         end else if (s1_word_ff.last_byte && !done_ff) begin
            rsp_valid_in              = 1'b1;
            rsp_word_in.found         = 1'b0;
            rsp_word_in.match_address = '0;
         end
      end
   end

   // next scan state
   always_comb begin
      done_in     = done_ff;
      fill_in     = fill_ff;
      position_in = position_ff;
      if (!done_ff) begin
         done_in     = match;
         fill_in     = fill_next;
         position_in = position_ff + OFFSET_BITS'(1);
      end
      if (s1_word_ff.last_byte) begin
         done_in     = 1'b0;
         fill_in     = '0;
         position_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff     <= 1'b0;
         fill_ff     <= '0;
         position_ff <= '0;
         for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            window_ff[i] <= '0;
         end
      end else if (process) begin
         done_ff     <= done_in;
         fill_ff     <= fill_in;
         position_ff <= position_in;
         for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            if (s1_word_ff.last_byte) begin
               window_ff[i] <= '0;
            end else if (!done_ff) begin
               window_ff[i] <= window_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

### tb/scan_result_checker.sv
`timescale 1ns / 100ps

module scan_result_checker
   import mbps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_word_type              req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_word_type              rsp_data,
   output int                        failures,
   output int                        pending,
   output int                        scanned
);

   // shadow copy of the configuration registers
   logic [2*CSR_DATA_BITS-1:0] pattern_bytes;
   logic [15:0]                wild_bits;
   logic [LEN_BITS-1:0]        pattern_len;
   logic [ADDR_BITS-1:0]       region_base;

   // shadow scan state, entry 0 holds the newest byte
   logic [7:0]             window_bytes [MAX_PATTERN_BYTES];
   logic [OFFSET_BITS-1:0] byte_index;
   logic                   hit_seen;
   int                     window_count;

   rsp_word_type expected_hits [$];
   int           mismatch_count = 0;
   int           scanned_count = 0;

   task automatic clear_scan();
      foreach (window_bytes[k]) window_bytes[k] = 8'h00;
      byte_index   = '0;
      hit_seen     = 1'b0;
      window_count = 0;
   endtask

   // advance the shadow scan by one byte and queue any result it causes
   task automatic scan_byte(input req_word_type w);
      int                     span;
      bit                     hit;
      logic [OFFSET_BITS-1:0] offset;
      rsp_word_type           result;
      // every accepted word counts, also the ones ignored after a match
      scanned_count++;
      if (!hit_seen) begin
         // length zero acts as one, lengths above the window saturate
         if (pattern_len == 0) span = 1;
         else if (pattern_len > MAX_PATTERN_BYTES) span = MAX_PATTERN_BYTES;
         else span = pattern_len;
         for (int k = MAX_PATTERN_BYTES - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
         window_bytes[0] = w.data_byte;
         if (window_count < MAX_PATTERN_BYTES) window_count++;
         // pattern byte j lines up with the byte that came span-1-j bytes ago
         hit = (window_count >= span);
         for (int j = 0; j < span; j++) begin
            if (!wild_bits[j] && window_bytes[span-1-j] != pattern_bytes[8*j +: 8]) hit = 1'b0;
         end
         if (hit) begin
            offset               = byte_index - OFFSET_BITS'(span - 1);
            result.found         = 1'b1;
            result.match_address = region_base + ADDR_BITS'(offset);
            expected_hits.push_back(result);
            hit_seen = 1'b1;
         end
         byte_index = byte_index + 1'b1;
      end
      if (w.last_byte) begin
         // region ended with nothing found
         if (!hit_seen) begin
            result = '0;
            expected_hits.push_back(result);
         end
         clear_scan();
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         pattern_bytes = '0;
         wild_bits     = '0;
         pattern_len   = LEN_BITS'(1);
         region_base   = '0;
         clear_scan();
         expected_hits.delete();
      end else begin
         // compare each accepted result word with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected result word, actual found=%0b address=%h",
                        $time, rsp_data.found, rsp_data.match_address);
               mismatch_count++;
            end else begin
               want = expected_hits.pop_front();
               if (rsp_data.found !== want.found) begin
                  $display("%0t: found mismatch, expected %0b actual %0b",
                           $time, want.found, rsp_data.found);
                  mismatch_count++;
               end
               if (rsp_data.match_address !== want.match_address) begin
                  $display("%0t: match_address mismatch, expected %h actual %h",
                           $time, want.match_address, rsp_data.match_address);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) scan_byte(req_data);
         // register writes, unused indexes change nothing
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PATTERN_LOW:    pattern_bytes[CSR_DATA_BITS-1:0] = csr_write_data;
               CSR_PATTERN_HIGH:   pattern_bytes[2*CSR_DATA_BITS-1:CSR_DATA_BITS] = csr_write_data;
               CSR_WILDCARD_MASK:  wild_bits = csr_write_data[15:0];
               CSR_PATTERN_LENGTH: pattern_len = csr_write_data[LEN_BITS-1:0];
               CSR_BASE_ADDRESS:   region_base = csr_write_data[ADDR_BITS-1:0];
               default: ;
            endcase
         end
      end
      failures <= mismatch_count;
      pending  <= expected_hits.size();
      scanned  <= scanned_count;
   end

endmodule

### tb/tb_masked_byte_pattern_scanner.sv
`timescale 1ns / 100ps

module tb_masked_byte_pattern_scanner;
   import mbps_pkg::*;

   localparam int ITEM_TARGET  = 1950;
   localparam int ROUND_BYTES  = 70;
   localparam int LONG_HOLD    = 120;
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_UNUSED = CSR_BASE_ADDRESS + 3'd1;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;
   logic                      req_valid;
   logic                      req_stall;
   req_word_type              req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_word_type              rsp_data;

   int failures;
   int pending;
   int scanned;

   int   sender_idle_pct;
   int   receiver_idle_pct;
   logic hold_request;
   bit   hold_taken;
   int   hold_left;
   int   cycle_count;

   // current pattern, used to build regions that match
   logic [2*CSR_DATA_BITS-1:0] cur_pattern;
   logic [15:0]                cur_wild;
   int                         cur_span;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   masked_byte_pattern_scanner dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

   scan_result_checker result_monitor (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .failures         (failures),
      .pending          (pending),
      .scanned          (scanned)
   );

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_masked_byte_pattern_scanner: errors");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      hold_taken = 1'b0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   // write all five registers, junk in the bits above the wildcard, length and base widths
   task automatic load_scan(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [15:0] wild, input logic [4:0] len,
                            input logic [47:0] base);
      write_reg(CSR_PATTERN_LOW, lo);
      write_reg(CSR_PATTERN_HIGH, hi);
      write_reg(CSR_WILDCARD_MASK, {16'($urandom), 32'($urandom), wild});
      write_reg(CSR_PATTERN_LENGTH, {32'($urandom), 27'($urandom), len});
      write_reg(CSR_BASE_ADDRESS, {16'($urandom), base});
      csr_write_enable <= 1'b0;
      cur_pattern = {hi, lo};
      cur_wild    = wild;
      if (len == 0) cur_span = 1;
      else if (len > MAX_PATTERN_BYTES) cur_span = MAX_PATTERN_BYTES;
      else cur_span = len;
   endtask

   // offer one byte, wait for it to be taken, then maybe idle
   task automatic push_byte(input logic [7:0] value, input logic last);
      req_valid <= 1'b1;
      req_data  <= {value, last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // stop sending and wait until every expected word has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one region, optionally with the pattern planted at a random place
   task automatic scan_region(input int length, input bit plant);
      int         at;
      logic [7:0] value;
      at = (plant && length >= cur_span) ? int'($urandom_range(length - cur_span)) : -1;
      for (int n = 0; n < length; n++) begin
         if (at >= 0 && n >= at && n < at + cur_span) begin
            value = cur_wild[n-at] ? 8'($urandom) : cur_pattern[8*(n-at) +: 8];
         end else if ($urandom_range(1)) begin
            value = 8'($urandom);
         end else begin
            value = cur_pattern[8*$urandom_range(cur_span - 1) +: 8];
         end
         push_byte(value, n == length - 1);
      end
   endtask

   task automatic random_scan_setup();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [15:0] wild;
      logic [4:0]  len;
      logic [47:0] base;
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case ($urandom_range(5))
         0: begin
            lo = '0;
            hi = '0;
         end
         1: begin
            lo = '1;
            hi = '1;
         end
         default: ;
      endcase
      case ($urandom_range(9))
         0: len = 5'd0;
         1: len = 5'd1;
         2: len = 5'd16;
         3: len = 5'($urandom_range(31, 17));
         default: len = 5'($urandom_range(15, 2));
      endcase
      case ($urandom_range(7))
         0: wild = '0;
         1: wild = '1;
         2: wild = 16'($urandom);
         default: wild = 16'($urandom & $urandom & $urandom);
      endcase
      case ($urandom_range(5))
         0: base = '0;
         1: base = '1;
         default: base = {16'($urandom), 32'($urandom)};
      endcase
      load_scan(lo, hi, wild, len, base);
   endtask

   initial begin
      int region_len;
      int round_start;
      bit hold_sent;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_PATTERN_LOW;
      csr_write_data   <= '0;
      hold_request     <= 1'b0;
      reset            <= 1'b1;
      sender_idle_pct   = 35;
      receiver_idle_pct = 47;
      cur_pattern = '0;
      cur_wild    = '0;
      cur_span    = 1;
      hold_sent   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset pattern is one zero byte: match mid-region, then an ignored byte
      push_byte(8'h5A, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      // region with no match
      push_byte(8'hFF, 1'b1);
      settle();

      // unused indexes must not disturb anything
      for (int k = 0; k < 3; k++) write_reg(CSR_INDEX_BITS'(CSR_FIRST_UNUSED + k), '1);
      // four bytes, second one wild, base close to the top of the address space
      load_scan(64'h0000_0000_80FF_0011, '1, 16'h0002, 5'd4, 48'hFFFF_FFFF_FFFE);
      // region shorter than the pattern
      push_byte(8'h11, 1'b0);
      push_byte(8'h00, 1'b1);
      // match on the final byte, address wraps to zero
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h11, 1'b0);
      push_byte(8'h42, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h80, 1'b1);
      settle();

      // length zero acts as a single byte
      load_scan(64'h0000_0000_80FF_0011, '0, 16'h0000, 5'd0, 48'h0);
      push_byte(8'h10, 1'b0);
      push_byte(8'h11, 1'b0);
      push_byte(8'h12, 1'b1);

      // random part in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 35;
               receiver_idle_pct = 47;
            end
            1: begin
               sender_idle_pct   = 47;
               receiver_idle_pct = 35;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         while (scanned < (phase + 1) * ITEM_TARGET / 3) begin
            settle();
            if (phase == 2 && !hold_sent) begin
               // every region hits on its first byte, so results pile up
               load_scan({$urandom, $urandom}, {$urandom, $urandom}, '1, 5'd1,
                         {16'($urandom), 32'($urandom)});
               hold_request <= 1'b1;
               hold_sent = 1'b1;
            end else begin
               random_scan_setup();
            end
            round_start = scanned;
            while (scanned - round_start < ROUND_BYTES) begin
               case ($urandom_range(9))
                  0: region_len = $urandom_range(cur_span, 1);
                  1: region_len = $urandom_range(60, 20);
                  default: region_len = $urandom_range(cur_span + 10, 1);
               endcase
               scan_region(region_len, $urandom_range(9) < 7);
            end
         end
      end

      settle();
      if (failures == 0) begin
         $display("tb_masked_byte_pattern_scanner: clean");
      end else begin
         $display("tb_masked_byte_pattern_scanner: errors");
      end
      $finish;
   end

endmodule
